FILE: rtl/core/scwd_pkg.sv
// ----------------------------------------------------------------------------
// scwd_pkg
// Types, constants and digit helpers for the settable clock with display.
// ----------------------------------------------------------------------------
package scwd_pkg;

  localparam int TICKS_PER_SECOND = 10;
  localparam int PHASE_W          = $clog2(TICKS_PER_SECOND + 1);

  localparam logic [4:0] TIMEOUT_RESET = 5'd20;
  localparam logic [5:0] SEC_MAX       = 6'd59;
  localparam logic [5:0] MIN_MAX       = 6'd59;
  localparam logic [4:0] HOUR_MAX      = 5'd23;
  localparam logic [7:0] SEG_BLANK     = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_MODE = 2'd1,
    KIND_UP   = 2'd2,
    KIND_DOWN = 2'd3
  } kind_t;

  // also used for the blanked pair: normal means nothing blanked
  typedef enum logic [1:0] {
    MODE_NORMAL      = 2'd0,
    MODE_SET_HOURS   = 2'd1,
    MODE_SET_MINUTES = 2'd2,
    MODE_SET_SECONDS = 2'd3
  } mode_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [1:0] set_mode;
    logic [7:0] seg_sec_ones;
    logic [7:0] seg_sec_tens;
    logic [7:0] seg_min_ones;
    logic [7:0] seg_min_tens;
    logic [7:0] seg_hour_ones;
    logic [7:0] seg_hour_tens;
  } res_t;

  // common-anode, active-low segment codes
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  // tens digit of a value 0..63 by compare ladder
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60)      t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    logic [5:0] rem;
    tens_x10 = 6'(tens_of(v)) * 6'd10;
    rem      = v - tens_x10;
    return rem[3:0];
  endfunction

endpackage

FILE: rtl/core/settable_clock_with_display_unit.sv
// ----------------------------------------------------------------------------
// settable_clock_with_display_unit
// Event-driven 24-hour clock with set mode, idle timeout and blinking display.
// ----------------------------------------------------------------------------
// The result of an accepted word is registered in the output register, or in the skid entry while the consumer stalls.
// Throughput: one word per cycle while in_stall is low; the state update is a single registered pass.
// A two-entry output stage (result + skid) keeps input flowing while the
// consumer stalls; in_stall rises only when both entries are full.
// Reset (rst, synchronous): time 00:00:00, normal mode, nothing blanked,
// idle count 0, idle timeout 20 s, output stage empty.
module settable_clock_with_display_unit
  import scwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration: idle timeout in seconds
  input  logic       cfg_write,
  input  logic [4:0] cfg_data,
  // event input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic       buttons_released,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] hours,
  output logic [5:0] minutes,
  output logic [5:0] seconds,
  output logic [1:0] set_mode,
  output logic [7:0] seg_sec_ones,
  output logic [7:0] seg_sec_tens,
  output logic [7:0] seg_min_ones,
  output logic [7:0] seg_min_tens,
  output logic [7:0] seg_hour_ones,
  output logic [7:0] seg_hour_tens
);

  // clock state
  logic [4:0]         idle_timeout;
  logic [PHASE_W-1:0] tick_phase, tick_phase_next;
  logic [5:0]         sec_count, sec_count_next;
  logic [5:0]         min_count, min_count_next;
  logic [4:0]         hour_count, hour_count_next;
  mode_t              mode_reg, mode_reg_next;
  logic [4:0]         idle_count, idle_count_next;
  mode_t              blanked_pair, blanked_pair_next;

  // output stage
  res_t res, res_next;
  res_t skid;
  logic skid_valid;

  logic               accept;
  logic               drain;
  logic [PHASE_W-1:0] phase_inc;
  logic [4:0]         idle_step;
  kind_t              ev;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign drain    = out_valid && !out_stall;
  assign ev       = kind_t'(kind);

  assign phase_inc = tick_phase + PHASE_W'(1);
  assign idle_step = (idle_count < idle_timeout) ? idle_count + 5'd1 : idle_count;

  // next clock state for the offered event
  always_comb begin
    tick_phase_next   = tick_phase;
    sec_count_next    = sec_count;
    min_count_next    = min_count;
    hour_count_next   = hour_count;
    mode_reg_next     = mode_reg;
    idle_count_next   = idle_count;
    blanked_pair_next = blanked_pair;

    case (ev)
      KIND_TICK: begin
        if (phase_inc >= PHASE_W'(TICKS_PER_SECOND)) begin
          tick_phase_next = phase_inc - PHASE_W'(TICKS_PER_SECOND);
          // one second: idle count saturates at the timeout
          idle_count_next = idle_step;
          if (idle_step >= idle_timeout) begin
            idle_count_next = idle_timeout;
            mode_reg_next   = MODE_NORMAL;
          end
          if (sec_count >= SEC_MAX) begin
            sec_count_next = '0;
            if (min_count >= MIN_MAX) begin
              min_count_next  = '0;
              hour_count_next = (hour_count >= HOUR_MAX) ? '0 : hour_count + 5'd1;
            end else begin
              min_count_next = min_count + 6'd1;
            end
          end else begin
            sec_count_next = sec_count + 6'd1;
          end
          blanked_pair_next = MODE_NORMAL;
        end else begin
          tick_phase_next = phase_inc;
        end
      end
      KIND_MODE: begin
        // no refresh here: a blanked pair stays blank unless the blink logic below changes it
        mode_reg_next   = mode_t'(mode_reg + 2'd1);
        idle_count_next = '0;
      end
      KIND_UP, KIND_DOWN: begin
        idle_count_next = '0;
        case (mode_reg)
          MODE_SET_HOURS: begin
            if (ev == KIND_UP)
              hour_count_next = (hour_count >= HOUR_MAX) ? '0 : hour_count + 5'd1;
            else
              hour_count_next = (hour_count == '0) ? HOUR_MAX : hour_count - 5'd1;
          end
          MODE_SET_MINUTES: begin
            if (ev == KIND_UP)
              min_count_next = (min_count >= MIN_MAX) ? '0 : min_count + 6'd1;
            else
              min_count_next = (min_count == '0) ? MIN_MAX : min_count - 6'd1;
          end
          MODE_SET_SECONDS: begin
            if (ev == KIND_UP)
              sec_count_next = (sec_count >= SEC_MAX) ? '0 : sec_count + 6'd1;
            else
              sec_count_next = (sec_count == '0) ? SEC_MAX : sec_count - 6'd1;
          end
          default: begin
          end
        endcase
        blanked_pair_next = MODE_NORMAL;
      end
      default: begin
      end
    endcase

    // blink: blank at phase 0 with buttons released, restore at mid-second
    if (mode_reg_next != MODE_NORMAL) begin
      if (tick_phase_next == '0 && buttons_released)
        blanked_pair_next = mode_reg_next;
      else if (tick_phase_next == PHASE_W'(TICKS_PER_SECOND / 2))
        blanked_pair_next = MODE_NORMAL;
    end
  end

  // result word from the updated state
  always_comb begin
    res_next.hours         = hour_count_next;
    res_next.minutes       = min_count_next;
    res_next.seconds       = sec_count_next;
    res_next.set_mode      = mode_reg_next;
    res_next.seg_sec_ones  = (blanked_pair_next == MODE_SET_SECONDS) ? SEG_BLANK
                           : seg_code(ones_of(sec_count_next));
    res_next.seg_sec_tens  = (blanked_pair_next == MODE_SET_SECONDS) ? SEG_BLANK
                           : seg_code(tens_of(sec_count_next));
    res_next.seg_min_ones  = (blanked_pair_next == MODE_SET_MINUTES) ? SEG_BLANK
                           : seg_code(ones_of(min_count_next));
    res_next.seg_min_tens  = (blanked_pair_next == MODE_SET_MINUTES) ? SEG_BLANK
                           : seg_code(tens_of(min_count_next));
    res_next.seg_hour_ones = (blanked_pair_next == MODE_SET_HOURS) ? SEG_BLANK
                           : seg_code(ones_of({1'b0, hour_count_next}));
    res_next.seg_hour_tens = (blanked_pair_next == MODE_SET_HOURS) ? SEG_BLANK
                           : seg_code(tens_of({1'b0, hour_count_next}));
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      idle_timeout <= cfg_data;
    end
  end

  // clock state commits on accepted words only
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase   <= '0;
      sec_count    <= '0;
      min_count    <= '0;
      hour_count   <= '0;
      mode_reg     <= MODE_NORMAL;
      idle_count   <= '0;
      blanked_pair <= MODE_NORMAL;
    end else if (accept) begin
      tick_phase   <= tick_phase_next;
      sec_count    <= sec_count_next;
      min_count    <= min_count_next;
      hour_count   <= hour_count_next;
      mode_reg     <= mode_reg_next;
      idle_count   <= idle_count_next;
      blanked_pair <= blanked_pair_next;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || drain) begin
      if (skid_valid)
        res <= skid;
      else if (accept)
        res <= res_next;
    end else if (accept) begin
      skid <= res_next;
    end
  end

  assign hours         = res.hours;
  assign minutes       = res.minutes;
  assign seconds       = res.seconds;
  assign set_mode      = res.set_mode;
  assign seg_sec_ones  = res.seg_sec_ones;
  assign seg_sec_tens  = res.seg_sec_tens;
  assign seg_min_ones  = res.seg_min_ones;
  assign seg_min_tens  = res.seg_min_tens;
  assign seg_hour_ones = res.seg_hour_ones;
  assign seg_hour_tens = res.seg_hour_tens;

endmodule

FILE: rtl/core/scwd_checker.sv
// ----------------------------------------------------------------------------
// scwd_checker
// Port-level checks on the settable clock with display.
// ----------------------------------------------------------------------------
module scwd_checker
  import scwd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] hours,
  input logic [5:0] minutes,
  input logic [5:0] seconds,
  input logic [7:0] seg_sec_ones,
  input logic [7:0] seg_sec_tens,
  input logic [7:0] seg_min_ones,
  input logic [7:0] seg_min_tens,
  input logic [7:0] seg_hour_ones,
  input logic [7:0] seg_hour_tens
);

  // time fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hours <= HOUR_MAX && minutes <= MIN_MAX && seconds <= SEC_MAX))
    else $error("time field out of range");

  // a digit pair blanks as a unit
  a_pair_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((seg_sec_ones == SEG_BLANK) == (seg_sec_tens == SEG_BLANK) &&
                   (seg_min_ones == SEG_BLANK) == (seg_min_tens == SEG_BLANK) &&
                   (seg_hour_ones == SEG_BLANK) == (seg_hour_tens == SEG_BLANK)))
    else $error("digit pair half blanked");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled word dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(hours) && $stable(minutes) && $stable(seconds))
    else $error("stalled word changed");

endmodule

bind settable_clock_with_display_unit scwd_checker u_scwd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .hours         (hours),
  .minutes       (minutes),
  .seconds       (seconds),
  .seg_sec_ones  (seg_sec_ones),
  .seg_sec_tens  (seg_sec_tens),
  .seg_min_ones  (seg_min_ones),
  .seg_min_tens  (seg_min_tens),
  .seg_hour_ones (seg_hour_ones),
  .seg_hour_tens (seg_hour_tens)
);
